// ----- rtl/dprf_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the depth point rectify filter.
package dprf_pkg;

  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = 13;
  localparam int PIX_W    = 12;
  localparam int REM_W    = $clog2(MAX_SIDE);
  localparam int DIFF_W   = SIDE_W + 1;
  localparam int DEPTH_W  = 31;
  localparam int LAT_W    = DEPTH_W + 1 + DIFF_W;
  localparam int DIV_W    = LAT_W - 2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_VALID = 2'd2;
  localparam logic [1:0] ST_NEG   = 2'd3;

  localparam logic [2:0] REG_CAM_X     = 3'd0;
  localparam logic [2:0] REG_CAM_Y     = 3'd1;
  localparam logic [2:0] REG_CAM_Z     = 3'd2;
  localparam logic [2:0] REG_FOCUS_X   = 3'd3;
  localparam logic [2:0] REG_FOCUS_Y   = 3'd4;
  localparam logic [2:0] REG_FOCUS_Z   = 3'd5;
  localparam logic [2:0] REG_SIDE      = 3'd6;
  localparam logic [2:0] REG_MAX_RANGE = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0]         col;
    logic [PIX_W-1:0]         row;
    logic [7:0]               b;
    logic [7:0]               g;
    logic [7:0]               r;
    logic [SIDE_W-1:0]        w;
    logic signed [DIFF_W-1:0] dcol;
    logic signed [DIFF_W-1:0] drow;
    logic [DEPTH_W-1:0]       depth;
    logic [1:0]               status;
    logic                     neg_x;
    logic                     neg_y;
  } side_t;

endpackage

// ----- rtl/depth_point_rectify_filter_core.sv -----
`timescale 1ns / 1ps
// Depth point rectify filter: fully pipelined projection of world points.
//
// One item enters per clock while in_stall is low, and one result leaves per
// item, in order. The pipeline has six arithmetic stages (offset, focus products, dot sum, depth
// and status, lateral products, magnitude), a 44-stage restoring divider that
// retires one quotient bit per stage for x and y in parallel, and the output
// register. in_stall is high only while a held result blocks the output.
module depth_point_rectify_filter_core import dprf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [PIX_W-1:0]          pixel_col,
  input  logic [PIX_W-1:0]          pixel_row,
  input  logic signed [31:0]        world_x,
  input  logic signed [31:0]        world_y,
  input  logic signed [31:0]        world_z,
  input  logic [7:0]                chan_zero,
  input  logic [7:0]                chan_one,
  input  logic [7:0]                chan_two,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PIX_W-1:0]          out_col,
  output logic [PIX_W-1:0]          out_row,
  output logic signed [31:0]        local_x,
  output logic signed [31:0]        local_y,
  output logic signed [31:0]        local_z,
  output logic [DEPTH_W-1:0]        depth_range,
  output logic [7:0]                blue,
  output logic [7:0]                green,
  output logic [7:0]                red,
  output logic [1:0]                status
);

  logic signed [31:0]  cam_x, cam_y, cam_z;
  logic signed [15:0]  focus_x, focus_y, focus_z;
  logic [SIDE_W-1:0]   image_side;
  logic [DEPTH_W-1:0]  max_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x      <= '0;
      cam_y      <= '0;
      cam_z      <= '0;
      focus_x    <= '0;
      focus_y    <= '0;
      focus_z    <= 16'sd16384;
      image_side <= SIDE_W'(640);
      max_range  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_X:     cam_x      <= cfg_data;
        REG_CAM_Y:     cam_y      <= cfg_data;
        REG_CAM_Z:     cam_z      <= cfg_data;
        REG_FOCUS_X:   focus_x    <= cfg_data[15:0];
        REG_FOCUS_Y:   focus_y    <= cfg_data[15:0];
        REG_FOCUS_Z:   focus_z    <= cfg_data[15:0];
        REG_SIDE:      image_side <= cfg_data[SIDE_W-1:0];
        REG_MAX_RANGE: max_range  <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: offsets, clamped side, lateral factors
  logic                s1_vld, s1_empty;
  logic signed [32:0]  s1_dx, s1_dy, s1_dz;
  side_t               s1_side, s1_side_next;
  logic [SIDE_W-1:0]   w_clamp;

  always_comb begin
    w_clamp = (image_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : image_side;
    s1_side_next        = '0;
    s1_side_next.col    = pixel_col;
    s1_side_next.row    = pixel_row;
    s1_side_next.b      = chan_two;
    s1_side_next.g      = chan_one;
    s1_side_next.r      = chan_zero;
    s1_side_next.w      = w_clamp;
    s1_side_next.dcol   = $signed({1'b0, w_clamp}) - $signed({1'b0, pixel_col, 1'b0});
    s1_side_next.drow   = $signed({1'b0, w_clamp}) - $signed({1'b0, pixel_row, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
    if (en) begin
      s1_dx    <= 33'(world_x) - 33'(cam_x);
      s1_dy    <= 33'(world_y) - 33'(cam_y);
      s1_dz    <= 33'(world_z) - 33'(cam_z);
      s1_empty <= (world_x == 0) || (world_y == 0) || (world_z == 0);
      s1_side  <= s1_side_next;
    end
  end

  // stage 2: focus products
  logic                s2_vld, s2_empty;
  logic signed [48:0]  s2_px, s2_py, s2_pz;
  side_t               s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
    if (en) begin
      s2_px    <= 49'(focus_x) * 49'(s1_dx);
      s2_py    <= 49'(focus_y) * 49'(s1_dy);
      s2_pz    <= 49'(focus_z) * 49'(s1_dz);
      s2_empty <= s1_empty;
      s2_side  <= s1_side;
    end
  end

  // stage 3: dot product
  logic                s3_vld, s3_empty;
  logic signed [50:0]  s3_dot;
  side_t               s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
    if (en) begin
      s3_dot   <= 51'(s2_px) + 51'(s2_py) + 51'(s2_pz);
      s3_empty <= s2_empty;
      s3_side  <= s2_side;
    end
  end

  // stage 4: depth, truncated toward zero, and status
  logic                s4_vld;
  side_t               s4_side, s4_side_next;
  logic signed [36:0]  depth_q;

  always_comb begin
    depth_q = $signed(s3_dot[50:14]) + 37'(s3_dot[50] && (s3_dot[13:0] != '0));
    s4_side_next = s3_side;
    s4_side_next.depth = '0;
    if (s3_empty) begin
      s4_side_next.status = ST_EMPTY;
    end else if (depth_q < 0) begin
      s4_side_next.status = ST_NEG;
    end else if (depth_q > $signed({6'b0, max_range})) begin
      s4_side_next.status = ST_RANGE;
    end else begin
      s4_side_next.status = ST_VALID;
      s4_side_next.depth  = depth_q[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
    if (en) begin
      s4_side <= s4_side_next;
    end
  end

  // stage 5: lateral numerators
  logic                    s5_vld;
  logic signed [LAT_W-1:0] s5_lx, s5_ly;
  side_t                   s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
    if (en) begin
      s5_lx   <= LAT_W'($signed({1'b0, s4_side.depth})) * LAT_W'(s4_side.dcol);
      s5_ly   <= LAT_W'($signed({1'b0, s4_side.depth})) * LAT_W'(s4_side.drow);
      s5_side <= s4_side;
    end
  end

  // stage 6 and divider: sign-magnitude restoring division by the side
  logic [DIV_W-1:0] dnq  [2][DIV_W+1];
  logic [REM_W-1:0] drem [2][DIV_W+1];
  logic             dvld [DIV_W+1];
  side_t            dside[DIV_W+1];
  side_t            s6_side_next;
  logic [LAT_W-1:0] mag_x, mag_y;

  always_comb begin
    mag_x = s5_lx[LAT_W-1] ? LAT_W'(-s5_lx) : LAT_W'(s5_lx);
    mag_y = s5_ly[LAT_W-1] ? LAT_W'(-s5_ly) : LAT_W'(s5_ly);
    s6_side_next       = s5_side;
    s6_side_next.neg_x = s5_lx[LAT_W-1];
    s6_side_next.neg_y = s5_ly[LAT_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (en) begin
      dvld[0] <= s5_vld;
    end
    if (en) begin
      dnq[0][0]  <= mag_x[DIV_W-1:0];
      dnq[1][0]  <= mag_y[DIV_W-1:0];
      drem[0][0] <= '0;
      drem[1][0] <= '0;
      dside[0]   <= s6_side_next;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [REM_W:0] shr [2];
    logic           ge  [2];

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      assign shr[ln] = {drem[ln][k], dnq[ln][k][DIV_W-1]};
      assign ge[ln]  = shr[ln] >= (REM_W+1)'(dside[k].w);

      always_ff @(posedge clk) begin
        if (en) begin
          dnq[ln][k+1]  <= {dnq[ln][k][DIV_W-2:0], ge[ln]};
          drem[ln][k+1] <= ge[ln] ? REM_W'(shr[ln] - (REM_W+1)'(dside[k].w))
                                  : shr[ln][REM_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else if (en) begin
        dvld[k+1] <= dvld[k];
      end
      if (en) begin
        dside[k+1] <= dside[k];
      end
    end
  end

  // output: sign, saturation, zeroing
  side_t              fs;
  logic signed [31:0] lat_res [2];
  logic               lat_neg [2];

  always_comb begin
    fs = dside[DIV_W];
    lat_neg[0] = fs.neg_x;
    lat_neg[1] = fs.neg_y;
    for (int i = 0; i < 2; i++) begin
      if (fs.w == '0) begin
        lat_res[i] = '0;
      end else if (lat_neg[i]) begin
        lat_res[i] = (dnq[i][DIV_W] >= DIV_W'(64'h8000_0000)) ? 32'sh8000_0000
                   : 32'(-$signed({1'b0, dnq[i][DIV_W]}));
      end else begin
        lat_res[i] = (dnq[i][DIV_W] > DIV_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                   : dnq[i][DIV_W][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvld[DIV_W];
    end
    if (en) begin
      out_col     <= fs.col;
      out_row     <= fs.row;
      status      <= fs.status;
      local_z     <= 32'(fs.depth);
      depth_range <= fs.depth;
      if (fs.status == ST_VALID) begin
        local_x <= lat_res[0];
        local_y <= lat_res[1];
        blue    <= fs.b;
        green   <= fs.g;
        red     <= fs.r;
      end else begin
        local_x <= '0;
        local_y <= '0;
        blue    <= '0;
        green   <= '0;
        red     <= '0;
      end
    end
  end

  a_zero_unless_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_VALID) |->
      local_x == 0 && local_y == 0 && local_z == 0 && depth_range == 0
      && blue == 0 && green == 0 && red == 0)
    else $error("non-valid result carries data");

  a_depth_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> local_z == 32'(depth_range))
    else $error("depth and range disagree");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(local_x) && $stable(local_y))
    else $error("held result changed under stall");

endmodule
